/* hdl/rmas_pkg.sv */
// shared constants, types and state codes of the range multiply/add/sum tree
`default_nettype none

package rmas_pkg;

    localparam int MAX_ELEMENTS = 65536;
    localparam int TREE_NODES   = 4 * MAX_ELEMENTS;
    localparam int NODE_W       = $clog2(TREE_NODES);
    localparam int IDX_W        = 17;
    localparam int VAL_W        = 31;
    localparam int CFG_IDX_W    = 1;
    localparam int STACK_DEPTH  = $clog2(MAX_ELEMENTS) + 2;
    localparam int SP_W         = $clog2(STACK_DEPTH + 1);
    localparam int STK_IW       = $clog2(STACK_DEPTH);
    localparam int MM_STEPS     = VAL_W;
    localparam int MM_CNT_W     = $clog2(MM_STEPS + 1);

    localparam logic [VAL_W-1:0] MODULUS_RESET = VAL_W'(2);
    localparam logic [VAL_W-1:0] MODULUS_MIN   = VAL_W'(2);
    localparam logic [IDX_W-1:0] COUNT_RESET   =
        IDX_W'((MAX_ELEMENTS < 65536) ? MAX_ELEMENTS : 65536);
    localparam logic [IDX_W-1:0] COUNT_MAX     = IDX_W'(MAX_ELEMENTS);

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        FN_SET   = 2'd0,
        FN_MUL   = 2'd1,
        FN_ADD   = 2'd2,
        FN_QUERY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        PH_ENTER,
        PH_RIGHT,
        PH_PULL
    } phase_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE_WAIT,
        ST_ENTER,
        ST_READ_NODE,
        ST_DECIDE,
        ST_READ_CHILD,
        ST_AP_START,
        ST_AP_WAIT,
        ST_WRITE_CHILD,
        ST_WRITE_NODE,
        ST_WRITE_FULL,
        ST_DESCEND,
        ST_PULL_L,
        ST_PULL_R,
        ST_POP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] mul;
        logic [VAL_W-1:0] add;
    } node_t;

    typedef struct packed {
        logic [NODE_W-1:0] k;
        logic [IDX_W-1:0]  l;
        logic [IDX_W-1:0]  r;
        phase_t            ph;
    } frame_t;

    localparam int NODE_BITS = $bits(node_t);

endpackage

`default_nettype wire

/* hdl/rmas_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module rmas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/rmas_mulmod.sv */
// bit-serial modular multiply-add unit: (x * y + z) mod m, x and z below m
`default_nettype none

module rmas_mulmod (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      abort,
    input  wire logic                      start,
    input  wire logic [rmas_pkg::VAL_W-1:0] x,
    input  wire logic [rmas_pkg::VAL_W-1:0] y,
    input  wire logic [rmas_pkg::VAL_W-1:0] z,
    input  wire logic [rmas_pkg::VAL_W-1:0] m,
    output logic                           done,
    output logic      [rmas_pkg::VAL_W-1:0] result
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [rmas_pkg::MM_CNT_W-1:0]    cnt_reg;
    logic [rmas_pkg::VAL_W-1:0]       acc_reg;
    logic [rmas_pkg::VAL_W-1:0]       x_reg;
    logic [rmas_pkg::VAL_W-1:0]       y_reg;
    logic [rmas_pkg::VAL_W-1:0]       z_reg;

    logic [rmas_pkg::VAL_W:0]         dbl;
    logic [rmas_pkg::VAL_W:0]         dbl_red;
    logic [rmas_pkg::VAL_W:0]         part;
    logic [rmas_pkg::VAL_W:0]         part_red;
    logic [rmas_pkg::VAL_W:0]         fin;
    logic [rmas_pkg::VAL_W:0]         fin_red;
    logic [rmas_pkg::VAL_W:0]         m_ext;

    // msb first: acc = 2*acc + bit*x, kept below m after each half step
    always_comb
    begin
        m_ext    = {1'b0, m};
        dbl      = {acc_reg, 1'b0};
        dbl_red  = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        part     = dbl_red + {1'b0, (y_reg[rmas_pkg::VAL_W-1] ? x_reg : '0)};
        part_red = (part >= m_ext) ? (part - m_ext) : part;
        fin      = {1'b0, acc_reg} + {1'b0, z_reg};
        fin_red  = (fin >= m_ext) ? (fin - m_ext) : fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (abort)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rmas_pkg::MM_CNT_W'(rmas_pkg::MM_STEPS);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
            z_reg   <= z;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_reg <= part_red[rmas_pkg::VAL_W-1:0];
                y_reg   <= {y_reg[rmas_pkg::VAL_W-2:0], 1'b0};
            end
            else
            begin
                acc_reg <= fin_red[rmas_pkg::VAL_W-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

/* hdl/range_mul_add_sum_mod_tree.sv */
// lazy segment tree over residues: set, range multiply, range add, range sum
// flow: operand reduction in the mulmod, then a walk over the visited nodes, plus
//   four mulmods per tag application; a push-down with pending tags applies two.
//   one word in flight, range_sum registered at the output.
// after reset and after every register write the tree is swept clear, all 262144 nodes,
//   one node a cycle through the single ram write port; no word is taken meanwhile
`default_nettype none

module range_mul_add_sum_mod_tree (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [rmas_pkg::IDX_W-1:0]    lo_index,
    input  wire logic [rmas_pkg::IDX_W-1:0]    hi_index,
    input  wire logic [rmas_pkg::VAL_W-1:0]    operand,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rmas_pkg::VAL_W-1:0]    range_sum,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rmas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rmas_pkg::VAL_W-1:0]    cfg_data
);

    rmas_pkg::state_t               state_reg;
    rmas_pkg::state_t               state_next;
    rmas_pkg::func_t                op_reg;
    logic [rmas_pkg::IDX_W-1:0]     lo_reg;
    logic [rmas_pkg::IDX_W-1:0]     hi_reg;
    logic [rmas_pkg::VAL_W-1:0]     val_reg;
    logic [rmas_pkg::VAL_W-1:0]     acc_reg;
    logic [rmas_pkg::VAL_W-1:0]     modulus_reg;
    logic [rmas_pkg::IDX_W-1:0]     count_reg;
    logic [rmas_pkg::NODE_W-1:0]    clr_cnt_reg;
    rmas_pkg::frame_t               cur_reg;
    rmas_pkg::frame_t               stack_reg [rmas_pkg::STACK_DEPTH];
    logic [rmas_pkg::SP_W-1:0]      sp_reg;
    rmas_pkg::node_t                node_reg;
    rmas_pkg::node_t                child_reg;
    logic                           child_sel_reg;
    logic                           ap_child_reg;
    logic [1:0]                     ap_step_reg;
    logic [rmas_pkg::VAL_W-1:0]     tm_reg;
    logic [rmas_pkg::VAL_W-1:0]     ta_reg;
    logic [rmas_pkg::IDX_W-1:0]     len_reg;
    logic [rmas_pkg::VAL_W-1:0]     new_sum_reg;
    logic [rmas_pkg::VAL_W-1:0]     new_mul_reg;
    logic [rmas_pkg::VAL_W-1:0]     new_add_reg;
    logic [rmas_pkg::VAL_W-1:0]     pull_sum_reg;
    logic                           out_valid_reg;
    logic [rmas_pkg::VAL_W-1:0]     range_sum_reg;

    logic                           cfg_write;
    logic                           in_accept;
    logic [rmas_pkg::IDX_W:0]       lr_sum;
    logic [rmas_pkg::IDX_W-1:0]     mid;
    logic [rmas_pkg::IDX_W-1:0]     left_len;
    logic [rmas_pkg::IDX_W-1:0]     right_len;
    logic [rmas_pkg::IDX_W-1:0]     full_len;
    logic                           covered;
    logic                           outside;
    logic                           set_leaf;
    logic                           tag_ident;
    logic                           set_bad;
    logic                           out_free;
    logic [rmas_pkg::NODE_W-1:0]    k_left;
    logic [rmas_pkg::NODE_W-1:0]    k_right;
    logic [rmas_pkg::NODE_W-1:0]    k_child;
    logic [rmas_pkg::VAL_W-1:0]     op_tm;
    logic [rmas_pkg::VAL_W-1:0]     op_ta;
    logic [rmas_pkg::STK_IW-1:0]    push_idx;
    logic [rmas_pkg::SP_W-1:0]      sp_dec;
    logic [rmas_pkg::STK_IW-1:0]    pop_idx;
    rmas_pkg::node_t                ap_w;
    rmas_pkg::frame_t               left_frame;
    rmas_pkg::frame_t               right_frame;
    rmas_pkg::frame_t               root_frame;
    rmas_pkg::frame_t               cur_pull_frame;
    rmas_pkg::frame_t               cur_right_frame;
    logic [rmas_pkg::IDX_W-1:0]     count_clamped;
    logic [rmas_pkg::VAL_W-1:0]     modulus_clamped;

    logic                           ram_we;
    logic [rmas_pkg::NODE_W-1:0]    ram_waddr;
    rmas_pkg::node_t                ram_wdata;
    logic [rmas_pkg::NODE_W-1:0]    ram_raddr;
    rmas_pkg::node_t                ram_rdata;
    logic [rmas_pkg::NODE_BITS-1:0] ram_rbits;

    logic                           mm_start;
    logic [rmas_pkg::VAL_W-1:0]     mm_x;
    logic [rmas_pkg::VAL_W-1:0]     mm_y;
    logic [rmas_pkg::VAL_W-1:0]     mm_z;
    logic                           mm_done;
    logic [rmas_pkg::VAL_W-1:0]     mm_result;

    function automatic logic [rmas_pkg::VAL_W-1:0] mod_add(
        input logic [rmas_pkg::VAL_W-1:0] a,
        input logic [rmas_pkg::VAL_W-1:0] b,
        input logic [rmas_pkg::VAL_W-1:0] m
    );
        logic [rmas_pkg::VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[rmas_pkg::VAL_W-1:0];
    endfunction

    rmas_ram #(
        .WIDTH (rmas_pkg::NODE_BITS),
        .DEPTH (rmas_pkg::TREE_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = ram_rbits;

    rmas_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .abort  (cfg_write),
        .start  (mm_start),
        .x      (mm_x),
        .y      (mm_y),
        .z      (mm_z),
        .m      (modulus_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign range_sum = range_sum_reg;

    always_comb
    begin
        lr_sum    = {1'b0, cur_reg.l} + {1'b0, cur_reg.r};
        mid       = lr_sum[rmas_pkg::IDX_W:1];
        left_len  = mid - cur_reg.l + 1'b1;
        right_len = cur_reg.r - mid;
        full_len  = cur_reg.r - cur_reg.l + 1'b1;
        covered   = (lo_reg <= cur_reg.l) && (cur_reg.r <= hi_reg);
        outside   = (cur_reg.l > hi_reg) || (cur_reg.r < lo_reg);
        set_leaf  = (cur_reg.l == cur_reg.r);
        tag_ident = (node_reg.mul == rmas_pkg::VAL_W'(1)) && (node_reg.add == '0);
        set_bad   = (op_reg == rmas_pkg::FN_SET)
                    && ((lo_reg == '0) || (lo_reg > count_reg));
        out_free  = !out_valid_reg || !out_stall;
        k_left    = {cur_reg.k[rmas_pkg::NODE_W-2:0], 1'b0};
        k_right   = {cur_reg.k[rmas_pkg::NODE_W-2:0], 1'b1};
        k_child   = child_sel_reg ? k_right : k_left;
        op_tm     = (op_reg == rmas_pkg::FN_MUL) ? val_reg : rmas_pkg::VAL_W'(1);
        op_ta     = (op_reg == rmas_pkg::FN_ADD) ? val_reg : '0;
        push_idx  = sp_reg[rmas_pkg::STK_IW-1:0];
        sp_dec    = sp_reg - 1'b1;
        pop_idx   = sp_dec[rmas_pkg::STK_IW-1:0];
        ap_w      = ap_child_reg ? child_reg : node_reg;

        left_frame.k  = k_left;
        left_frame.l  = cur_reg.l;
        left_frame.r  = mid;
        left_frame.ph = rmas_pkg::PH_ENTER;
        right_frame.k  = k_right;
        right_frame.l  = mid + 1'b1;
        right_frame.r  = cur_reg.r;
        right_frame.ph = rmas_pkg::PH_ENTER;
        root_frame.k  = rmas_pkg::NODE_W'(1);
        root_frame.l  = rmas_pkg::IDX_W'(1);
        root_frame.r  = count_reg;
        root_frame.ph = rmas_pkg::PH_ENTER;
        cur_pull_frame     = cur_reg;
        cur_pull_frame.ph  = rmas_pkg::PH_PULL;
        cur_right_frame    = cur_reg;
        cur_right_frame.ph = rmas_pkg::PH_RIGHT;

        modulus_clamped = (cfg_data < rmas_pkg::MODULUS_MIN) ? rmas_pkg::MODULUS_MIN
                                                             : cfg_data;
        if (cfg_data[rmas_pkg::IDX_W-1:0] == '0)
        begin
            count_clamped = rmas_pkg::IDX_W'(1);
        end
        else if ({1'b0, cfg_data[rmas_pkg::IDX_W-1:0]} > {1'b0, rmas_pkg::COUNT_MAX})
        begin
            count_clamped = rmas_pkg::COUNT_MAX;
        end
        else
        begin
            count_clamped = cfg_data[rmas_pkg::IDX_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmas_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == rmas_pkg::NODE_W'(rmas_pkg::TREE_NODES - 1))
                begin
                    state_next = rmas_pkg::ST_IDLE;
                end
            end
            rmas_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = rmas_pkg::ST_REDUCE_WAIT;
                end
            end
            rmas_pkg::ST_REDUCE_WAIT:
            begin
                if (mm_done)
                begin
                    state_next = set_bad ? rmas_pkg::ST_IDLE : rmas_pkg::ST_ENTER;
                end
            end
            rmas_pkg::ST_ENTER:
            begin
                case (cur_reg.ph)
                    rmas_pkg::PH_ENTER:
                    begin
                        if (op_reg != rmas_pkg::FN_SET && outside)
                        begin
                            state_next = rmas_pkg::ST_POP;
                        end
                        else
                        begin
                            state_next = rmas_pkg::ST_READ_NODE;
                        end
                    end
                    rmas_pkg::PH_RIGHT:
                    begin
                        state_next = rmas_pkg::ST_ENTER;
                    end
                    default:
                    begin
                        state_next = (op_reg == rmas_pkg::FN_QUERY) ? rmas_pkg::ST_POP
                                                                   : rmas_pkg::ST_PULL_L;
                    end
                endcase
            end
            rmas_pkg::ST_READ_NODE:
            begin
                state_next = rmas_pkg::ST_DECIDE;
            end
            rmas_pkg::ST_DECIDE:
            begin
                if (op_reg == rmas_pkg::FN_QUERY && covered)
                begin
                    state_next = rmas_pkg::ST_POP;
                end
                else if ((op_reg == rmas_pkg::FN_MUL || op_reg == rmas_pkg::FN_ADD)
                         && covered)
                begin
                    state_next = rmas_pkg::ST_AP_START;
                end
                else if (op_reg == rmas_pkg::FN_SET && set_leaf)
                begin
                    state_next = rmas_pkg::ST_POP;
                end
                else if (tag_ident)
                begin
                    state_next = rmas_pkg::ST_DESCEND;
                end
                else
                begin
                    state_next = rmas_pkg::ST_READ_CHILD;
                end
            end
            rmas_pkg::ST_READ_CHILD:
            begin
                state_next = rmas_pkg::ST_AP_START;
            end
            rmas_pkg::ST_AP_START:
            begin
                state_next = rmas_pkg::ST_AP_WAIT;
            end
            rmas_pkg::ST_AP_WAIT:
            begin
                if (mm_done)
                begin
                    if (ap_step_reg != 2'd3)
                    begin
                        state_next = rmas_pkg::ST_AP_START;
                    end
                    else
                    begin
                        state_next = ap_child_reg ? rmas_pkg::ST_WRITE_CHILD
                                                  : rmas_pkg::ST_WRITE_FULL;
                    end
                end
            end
            rmas_pkg::ST_WRITE_CHILD:
            begin
                state_next = child_sel_reg ? rmas_pkg::ST_WRITE_NODE
                                           : rmas_pkg::ST_READ_CHILD;
            end
            rmas_pkg::ST_WRITE_NODE:
            begin
                state_next = rmas_pkg::ST_DESCEND;
            end
            rmas_pkg::ST_WRITE_FULL:
            begin
                state_next = rmas_pkg::ST_POP;
            end
            rmas_pkg::ST_DESCEND:
            begin
                state_next = rmas_pkg::ST_ENTER;
            end
            rmas_pkg::ST_PULL_L:
            begin
                state_next = rmas_pkg::ST_PULL_R;
            end
            rmas_pkg::ST_PULL_R:
            begin
                state_next = rmas_pkg::ST_POP;
            end
            rmas_pkg::ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = (op_reg == rmas_pkg::FN_QUERY) ? rmas_pkg::ST_FINISH
                                                               : rmas_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rmas_pkg::ST_ENTER;
                end
            end
            rmas_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rmas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmas_pkg::ST_CLEAR;
            end
        endcase
        if (cfg_write)
        begin
            state_next = rmas_pkg::ST_CLEAR;
        end
    end

    // ram, mulmod and handshake controls
    always_comb
    begin
        // no word is taken in the cycle of a register write
        in_stall  = (state_reg != rmas_pkg::ST_IDLE) || cfg_valid;
        ram_we    = 1'b0;
        ram_waddr = cur_reg.k;
        ram_wdata = node_reg;
        ram_raddr = cur_reg.k;
        mm_start  = 1'b0;
        mm_x      = rmas_pkg::VAL_W'(1);
        mm_y      = operand;
        mm_z      = '0;
        case (state_reg)
            rmas_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_cnt_reg;
                ram_wdata.sum = '0;
                ram_wdata.mul = rmas_pkg::VAL_W'(1);
                ram_wdata.add = '0;
            end
            rmas_pkg::ST_IDLE:
            begin
                // operand mod m as operand * 1 mod m
                mm_start = in_accept;
            end
            rmas_pkg::ST_ENTER:
            begin
                ram_raddr = (cur_reg.ph == rmas_pkg::PH_PULL) ? k_left : cur_reg.k;
            end
            rmas_pkg::ST_DECIDE:
            begin
                ram_raddr = k_left;
                if (op_reg == rmas_pkg::FN_SET && set_leaf)
                begin
                    ram_we        = 1'b1;
                    ram_wdata.sum = val_reg;
                end
            end
            rmas_pkg::ST_AP_START:
            begin
                mm_start = 1'b1;
                case (ap_step_reg)
                    2'd0:
                    begin
                        mm_x = ap_w.sum;
                        mm_y = tm_reg;
                        mm_z = '0;
                    end
                    2'd1:
                    begin
                        mm_x = ta_reg;
                        mm_y = rmas_pkg::VAL_W'(len_reg);
                        mm_z = new_sum_reg;
                    end
                    2'd2:
                    begin
                        mm_x = ap_w.mul;
                        mm_y = tm_reg;
                        mm_z = '0;
                    end
                    default:
                    begin
                        mm_x = ap_w.add;
                        mm_y = tm_reg;
                        mm_z = ta_reg;
                    end
                endcase
            end
            rmas_pkg::ST_WRITE_CHILD:
            begin
                ram_we        = 1'b1;
                ram_waddr     = k_child;
                ram_wdata.sum = new_sum_reg;
                ram_wdata.mul = new_mul_reg;
                ram_wdata.add = new_add_reg;
                ram_raddr     = k_right;
            end
            rmas_pkg::ST_WRITE_NODE:
            begin
                ram_we        = 1'b1;
                ram_wdata.sum = node_reg.sum;
                ram_wdata.mul = rmas_pkg::VAL_W'(1);
                ram_wdata.add = '0;
            end
            rmas_pkg::ST_WRITE_FULL:
            begin
                ram_we        = 1'b1;
                ram_wdata.sum = new_sum_reg;
                ram_wdata.mul = new_mul_reg;
                ram_wdata.add = new_add_reg;
            end
            rmas_pkg::ST_PULL_L:
            begin
                ram_raddr = k_right;
            end
            rmas_pkg::ST_PULL_R:
            begin
                // tags of this node were pushed on the way down
                ram_we        = 1'b1;
                ram_wdata.sum = mod_add(pull_sum_reg, ram_rdata.sum, modulus_reg);
                ram_wdata.mul = rmas_pkg::VAL_W'(1);
                ram_wdata.add = '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmas_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= rmas_pkg::MODULUS_RESET;
            count_reg     <= rmas_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == rmas_pkg::ST_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                clr_cnt_reg <= '0;
                if (cfg_index == rmas_pkg::CFG_MODULUS)
                begin
                    modulus_reg <= modulus_clamped;
                end
                else
                begin
                    count_reg <= count_clamped;
                end
            end
            else
            begin
                case (state_reg)
                    rmas_pkg::ST_CLEAR:
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                    rmas_pkg::ST_REDUCE_WAIT:
                    begin
                        sp_reg <= '0;
                    end
                    rmas_pkg::ST_ENTER:
                    begin
                        if (cur_reg.ph == rmas_pkg::PH_RIGHT)
                        begin
                            sp_reg <= sp_reg + 1'b1;
                        end
                    end
                    rmas_pkg::ST_DESCEND:
                    begin
                        sp_reg <= sp_reg + 1'b1;
                    end
                    rmas_pkg::ST_POP:
                    begin
                        if (sp_reg != '0)
                        begin
                            sp_reg <= sp_dec;
                        end
                    end
                    default:
                    begin
                        sp_reg <= sp_reg;
                    end
                endcase
            end
        end
    end

    // traversal datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rmas_pkg::ST_IDLE:
            begin
                op_reg <= rmas_pkg::func_t'(func);
                lo_reg <= lo_index;
                hi_reg <= hi_index;
            end
            rmas_pkg::ST_REDUCE_WAIT:
            begin
                val_reg <= mm_result;
                acc_reg <= '0;
                cur_reg <= root_frame;
            end
            rmas_pkg::ST_ENTER:
            begin
                if (cur_reg.ph == rmas_pkg::PH_RIGHT)
                begin
                    stack_reg[push_idx] <= cur_pull_frame;
                    cur_reg             <= right_frame;
                end
            end
            rmas_pkg::ST_READ_NODE:
            begin
                node_reg <= ram_rdata;
            end
            rmas_pkg::ST_DECIDE:
            begin
                ap_step_reg   <= 2'd0;
                child_sel_reg <= 1'b0;
                if (op_reg == rmas_pkg::FN_QUERY && covered)
                begin
                    acc_reg <= mod_add(acc_reg, node_reg.sum, modulus_reg);
                end
                // a set always pushes its tags down, whatever hi_index says
                if (covered && op_reg != rmas_pkg::FN_SET)
                begin
                    ap_child_reg <= 1'b0;
                    tm_reg       <= op_tm;
                    ta_reg       <= op_ta;
                    len_reg      <= full_len;
                end
                else
                begin
                    ap_child_reg <= 1'b1;
                    tm_reg       <= node_reg.mul;
                    ta_reg       <= node_reg.add;
                end
            end
            rmas_pkg::ST_READ_CHILD:
            begin
                child_reg   <= ram_rdata;
                ap_step_reg <= 2'd0;
                len_reg     <= child_sel_reg ? right_len : left_len;
            end
            rmas_pkg::ST_AP_WAIT:
            begin
                if (mm_done)
                begin
                    ap_step_reg <= ap_step_reg + 1'b1;
                    case (ap_step_reg)
                        2'd0:    new_sum_reg <= mm_result;
                        2'd1:    new_sum_reg <= mm_result;
                        2'd2:    new_mul_reg <= mm_result;
                        default: new_add_reg <= mm_result;
                    endcase
                end
            end
            rmas_pkg::ST_WRITE_CHILD:
            begin
                child_sel_reg <= 1'b1;
            end
            rmas_pkg::ST_DESCEND:
            begin
                if (op_reg == rmas_pkg::FN_SET)
                begin
                    stack_reg[push_idx] <= cur_pull_frame;
                    cur_reg <= (lo_reg <= mid) ? left_frame : right_frame;
                end
                else
                begin
                    stack_reg[push_idx] <= cur_right_frame;
                    cur_reg <= left_frame;
                end
            end
            rmas_pkg::ST_PULL_L:
            begin
                pull_sum_reg <= ram_rdata.sum;
            end
            rmas_pkg::ST_POP:
            begin
                if (sp_reg != '0)
                begin
                    cur_reg <= stack_reg[pop_idx];
                end
            end
            rmas_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    range_sum_reg <= acc_reg;
                end
            end
            default:
            begin
                ap_step_reg <= ap_step_reg;
            end
        endcase
    end

    // the walk never goes deeper than the tree height
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= rmas_pkg::SP_W'(rmas_pkg::STACK_DEPTH))
        else $error("traversal stack overflow");

    // a mulmod result only arrives while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == rmas_pkg::ST_AP_WAIT
                     || state_reg == rmas_pkg::ST_REDUCE_WAIT))
        else $error("mulmod result with no sequencer waiting");

    // multiplicand of the serial unit must already be a residue
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_start |-> (mm_x < modulus_reg))
        else $error("mulmod operand not reduced");

    // node zero is unused outside the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != rmas_pkg::ST_CLEAR) |-> (ram_waddr != '0))
        else $error("write to node zero");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// testbench for the range multiply/add/sum tree: driver, monitor and predictor
`default_nettype none

module tb_top;
    import rmas_pkg::*;

    localparam int  NODES       = 4 * MAX_ELEMENTS;
    localparam int  SETTLE_WAIT = 30000;
    localparam int  LONG_HOLD   = 3000;
    localparam longint CYCLE_LIMIT = 40000000;

    typedef struct {
        func_t             fn;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [VAL_W-1:0]  val;
    } req_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           func;
    logic [IDX_W-1:0]     lo_index;
    logic [IDX_W-1:0]     hi_index;
    logic [VAL_W-1:0]     operand;
    logic                 out_valid;
    logic                 out_stall;
    logic [VAL_W-1:0]     range_sum;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;

    range_mul_add_sum_mod_tree dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .lo_index  (lo_index),
        .hi_index  (hi_index),
        .operand   (operand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .range_sum (range_sum),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    bit [VAL_W-1:0]  tree_sum [NODES];
    bit [VAL_W-1:0]  tree_mul [NODES];
    bit [VAL_W-1:0]  tree_add [NODES];
    longint unsigned cur_mod;
    longint unsigned cur_count;

    req_t            pending_reqs[$];
    logic [VAL_W-1:0] expected_sums[$];

    logic   in_taken;
    logic   quiet;
    logic   sender_pause;
    logic   want_hold;
    logic   hold_started;
    int     hold_cnt;
    int     errors;
    int     words_in;
    int     sums_checked;
    int     cfg_writes;
    longint cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void clear_tree();
        for (int i = 0; i < NODES; i++)
        begin
            tree_sum[i] = '0;
            tree_mul[i] = VAL_W'(1);
            tree_add[i] = '0;
        end
    endfunction

    function automatic void tag_node(longint unsigned k, longint unsigned len,
                                     longint unsigned m, longint unsigned a);
        if (k >= NODES)
            return;
        tree_sum[k] = VAL_W'((longint'(tree_sum[k]) * m + a * len) % cur_mod);
        tree_mul[k] = VAL_W'((longint'(tree_mul[k]) * m) % cur_mod);
        tree_add[k] = VAL_W'((longint'(tree_add[k]) * m + a) % cur_mod);
    endfunction

    function automatic void push_tags(longint unsigned k, longint unsigned l,
                                      longint unsigned r);
        longint unsigned mid;
        mid = (l + r) >> 1;
        if (k >= NODES)
            return;
        tag_node(2 * k, mid - l + 1, tree_mul[k], tree_add[k]);
        tag_node(2 * k + 1, r - mid, tree_mul[k], tree_add[k]);
        tree_mul[k] = VAL_W'(1);
        tree_add[k] = '0;
    endfunction

    function automatic void pull_sum(longint unsigned k);
        if (2 * k + 1 >= NODES)
            return;
        tree_sum[k] = VAL_W'((longint'(tree_sum[2 * k]) + tree_sum[2 * k + 1]) % cur_mod);
    endfunction

    function automatic void update_range(longint unsigned k, longint unsigned l,
                                         longint unsigned r, longint unsigned lo,
                                         longint unsigned hi, longint unsigned m,
                                         longint unsigned a);
        longint unsigned mid;
        mid = (l + r) >> 1;
        if (k >= NODES || l > hi || r < lo)
            return;
        if (lo <= l && r <= hi)
        begin
            tag_node(k, r - l + 1, m, a);
            return;
        end
        push_tags(k, l, r);
        update_range(2 * k, l, mid, lo, hi, m, a);
        update_range(2 * k + 1, mid + 1, r, lo, hi, m, a);
        pull_sum(k);
    endfunction

    function automatic void set_leaf(longint unsigned k, longint unsigned l,
                                     longint unsigned r, longint unsigned pos,
                                     longint unsigned v);
        longint unsigned mid;
        mid = (l + r) >> 1;
        if (k >= NODES)
            return;
        if (l == r)
        begin
            tree_sum[k] = VAL_W'(v);
            return;
        end
        push_tags(k, l, r);
        if (pos <= mid)
            set_leaf(2 * k, l, mid, pos, v);
        else
            set_leaf(2 * k + 1, mid + 1, r, pos, v);
        pull_sum(k);
    endfunction

    function automatic longint unsigned sum_range(longint unsigned k, longint unsigned l,
                                                  longint unsigned r, longint unsigned lo,
                                                  longint unsigned hi);
        longint unsigned mid;
        longint unsigned s;
        mid = (l + r) >> 1;
        if (k >= NODES || l > hi || r < lo)
            return 0;
        if (lo <= l && r <= hi)
            return tree_sum[k];
        push_tags(k, l, r);
        s = sum_range(2 * k, l, mid, lo, hi);
        s += sum_range(2 * k + 1, mid + 1, r, lo, hi);
        return s % cur_mod;
    endfunction

    function automatic void apply_request(req_t q);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned v;
        lo = q.lo;
        hi = q.hi;
        v  = longint'(q.val) % cur_mod;
        case (q.fn)
            FN_SET:
                if (lo >= 1 && lo <= cur_count)
                    set_leaf(1, 1, cur_count, lo, v);
            FN_MUL:
                update_range(1, 1, cur_count, lo, hi, v, 0);
            FN_ADD:
                update_range(1, 1, cur_count, lo, hi, 1, v);
            default:
                expected_sums.push_back(VAL_W'(sum_range(1, 1, cur_count, lo, hi)));
        endcase
    endfunction

    function automatic void note_register(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
        longint unsigned x;
        x = d;
        if (idx == CFG_MODULUS)
            cur_mod = (x < 2) ? 2 : x;
        else
        begin
            x = x & 64'h1FFFF;
            cur_count = (x < 1) ? 1 : ((x > MAX_ELEMENTS) ? MAX_ELEMENTS : x);
        end
        clear_tree();
    endfunction

    // input word taken and folded into the predictor
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            apply_request('{fn: func_t'(func), lo: lo_index, hi: hi_index, val: operand});
            words_in <= words_in + 1;
        end
    end

    // sender
    always @(negedge clk)
    begin
        if (!(in_valid && !in_taken))
        begin
            if (pending_reqs.size() != 0 && !sender_pause &&
                (quiet || $urandom_range(0, 99) >= 27))
            begin
                in_valid <= 1'b1;
                func     <= pending_reqs[0].fn;
                lo_index <= pending_reqs[0].lo;
                hi_index <= pending_reqs[0].hi;
                operand  <= pending_reqs[0].val;
                void'(pending_reqs.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold-off
    always @(negedge clk)
    begin
        if (want_hold && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_cnt     <= LONG_HOLD;
            out_stall    <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 27);
    end

    // result checker
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected range_sum %0d", $time, range_sum);
                errors <= errors + 1;
            end
            else
            begin
                if (range_sum !== expected_sums[0])
                begin
                    $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                             $time, expected_sums[0], range_sum);
                    errors <= errors + 1;
                end
                void'(expected_sums.pop_front());
                sums_checked <= sums_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_req(func_t fn, int lo, int hi, logic [VAL_W-1:0] v);
        pending_reqs.push_back('{fn: fn, lo: IDX_W'(lo), hi: IDX_W'(hi), val: v});
    endtask

    task automatic push_random(int n);
        req_t q;
        int   pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            q.fn = (pick < 2) ? FN_SET : (pick < 4) ? FN_MUL : (pick < 7) ? FN_ADD : FN_QUERY;
            if ($urandom_range(0, 99) < 88)
            begin
                q.lo = IDX_W'($urandom_range(1, cur_count));
                q.hi = IDX_W'($urandom_range(q.lo, cur_count));
            end
            else
            begin
                // noise: indices anywhere in the field, often reversed
                q.lo = IDX_W'($urandom);
                q.hi = IDX_W'($urandom);
            end
            if ($urandom_range(0, 3) == 0)
                q.val = VAL_W'($urandom_range(0, 5));
            else
                q.val = VAL_W'($urandom);
            pending_reqs.push_back(q);
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_sums.size() != 0)
            @(posedge clk);
        // words without a result may still be in progress
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        note_register(idx, d);
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = '0;
        lo_index     = '0;
        hi_index     = '0;
        operand      = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_taken     = 1'b0;
        quiet        = 1'b0;
        sender_pause = 1'b0;
        want_hold    = 1'b0;
        hold_started = 1'b0;
        hold_cnt     = 0;
        errors       = 0;
        words_in     = 0;
        sums_checked = 0;
        cfg_writes   = 0;
        cycles       = 0;
        cur_mod      = MODULUS_RESET;
        cur_count    = COUNT_RESET;
        clear_tree();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, full array: edges and out-of-range indices
        push_req(FN_SET, 1, 0, 31'd5);
        push_req(FN_SET, 65536, 0, 31'h7FFFFFFF);
        push_req(FN_SET, 0, 3, 31'd1);
        push_req(FN_SET, 65537, 0, 31'd1);
        push_req(FN_ADD, 1, 65536, 31'd1);
        push_req(FN_MUL, 2, 65535, 31'd3);
        push_req(FN_QUERY, 1, 65536, 31'd0);
        push_req(FN_QUERY, 65536, 65536, 31'd0);
        push_req(FN_QUERY, 5, 3, 31'd0);
        push_req(FN_QUERY, 0, 0, 31'd0);
        push_req(FN_QUERY, 65537, 131071, 31'd0);
        push_req(FN_ADD, 0, 131071, 31'h7FFFFFFF);
        push_req(FN_QUERY, 1, 1, 31'd0);
        push_req(FN_MUL, 1, 65536, 31'd0);
        push_req(FN_QUERY, 1, 65536, 31'd0);
        drain();

        // single element, largest modulus
        write_register(CFG_COUNT, 31'd0);
        write_register(CFG_MODULUS, 31'h7FFFFFFF);
        push_req(FN_SET, 1, 0, 31'h7FFFFFFF);
        push_req(FN_ADD, 1, 1, 31'h7FFFFFFE);
        push_req(FN_MUL, 1, 1, 31'h7FFFFFFE);
        push_req(FN_QUERY, 1, 1, 31'd0);
        push_req(FN_SET, 2, 0, 31'd9);
        push_req(FN_QUERY, 0, 2, 31'd0);
        drain();

        // small array, random traffic, one long receiver hold-off
        write_register(CFG_COUNT, 31'd23);
        want_hold = 1'b1;
        push_random(700);
        drain();

        // small modulus, quiet stretch and one sender pause
        write_register(CFG_MODULUS, VAL_W'($urandom_range(3, 1000)));
        push_random(300);
        while (pending_reqs.size() != 0)
            @(posedge clk);
        sender_pause = 1'b1;
        while (expected_sums.size() != 0 || in_valid)
            @(posedge clk);
        sender_pause = 1'b0;
        push_random(350);
        quiet = 1'b1;
        while (pending_reqs.size() > 150)
            @(posedge clk);
        quiet = 1'b0;
        drain();

        // count above the maximum and modulus below two, full array again
        write_register(CFG_COUNT, 31'h1FFFF);
        write_register(CFG_MODULUS, 31'd0);
        push_req(FN_ADD, 1, 65536, 31'd3);
        push_req(FN_QUERY, 1, 65536, 31'd0);
        push_req(FN_QUERY, 100, 200, 31'd0);
        drain();

        $display("%0d words accepted over %0d register writes, %0d sums checked",
                 words_in, cfg_writes, sums_checked);
        $display("covered set/multiply/add/query, clipped ranges and register extremes");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
